[design/modular_arithmetic_unit_assert.svh]
// Assertion macros used by the port checker.
`ifndef MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define MAU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define MAU_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) else $error("assertion failed");

`endif

[design/mau_pkg.sv]
// Types, opcodes and commands of the modular arithmetic unit.
`timescale 1ns / 1ps
package mau_pkg;

    localparam int RES_W = 31;
    localparam int WIDE_W = 64;
    localparam int CNT_W = 7;
    localparam logic [RES_W-1:0] MOD_RESET = 31'd1000000007;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_NEG = 4'd4;
    localparam logic [3:0] OP_INC = 4'd5;
    localparam logic [3:0] OP_DEC = 4'd6;
    localparam logic [3:0] OP_RED = 4'd7;
    localparam logic [3:0] OP_EQ  = 4'd8;

    typedef struct packed {
        logic [3:0]              op;
        logic [RES_W-1:0]        operand_a;
        logic [RES_W-1:0]        operand_b;
        logic signed [WIDE_W-1:0] wide_value;
    } mau_in_t;

    typedef struct packed {
        logic [RES_W-1:0] result;
        logic             not_invertible;
    } mau_out_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_STEP,
        CMD_SAVE_A,
        CMD_SAVE_B,
        CMD_MUL,
        CMD_RP_INIT,
        CMD_RW_INIT,
        CMD_EU_INIT,
        CMD_DV_INIT,
        CMD_EU_UPD,
        CMD_FINISH
    } mau_cmd_e_t;

    typedef struct packed {
        mau_cmd_e_t code;
    } mau_cmd_t;

    typedef struct packed {
        logic       last;
        logic       rb_zero;
        logic       ra_one;
        logic       out_busy;
        logic [3:0] op;
    } mau_stat_t;

endpackage

[design/mau_datapath.sv]
// Datapath: serial remainder unit, Euclid registers, multiplier and output register.
`timescale 1ns / 1ps
module mau_datapath
    import mau_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [RES_W-1:0]    cfg_wr_data,
    input  mau_in_t             s_data,
    input  mau_cmd_t            cmd,
    output mau_stat_t           stat,
    output logic                m_valid,
    input  logic                m_ready,
    output mau_out_t            m_data
);

    logic [RES_W-1:0]   mod_reg, mod_next;
    logic [3:0]         op_reg, op_next;
    logic [RES_W-1:0]   a_reg, a_next, b_reg, b_next;
    logic               neg_reg, neg_next;
    logic [WIDE_W-1:0]  wide_reg, wide_next;
    logic [WIDE_W-1:0]  num_reg, num_next;
    logic [RES_W-1:0]   rem_reg, rem_next;
    logic [RES_W-1:0]   div_reg, div_next;
    logic [RES_W-1:0]   acc_reg, acc_next;
    logic [RES_W-1:0]   x0_reg, x0_next, x1_reg, x1_next;
    logic [RES_W-1:0]   ra_reg, ra_next, rb_reg, rb_next;
    logic [2*RES_W-1:0] prod_reg, prod_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;
    mau_out_t           m_data_reg, m_data_next;

    logic [RES_W-1:0] m_eff;
    logic [RES_W:0]   mz, rem_sh, dbl, sum, t_wide;
    logic             qbit;
    logic [RES_W-1:0] rem_new, dbl_r, acc_new, t_val, mul_src;
    logic [WIDE_W-1:0] mag;
    mau_out_t         fin;
    logic [RES_W:0]   s_add, a_inc;

    assign m_eff = (mod_reg < 31'd2) ? 31'd1 : mod_reg;
    assign mz    = {1'b0, m_eff};

    // one restoring-division bit; the quotient bit also folds into acc = q * x1 mod m
    assign rem_sh  = {rem_reg, num_reg[WIDE_W-1]};
    assign qbit    = rem_sh >= {1'b0, div_reg};
    assign rem_new = qbit ? RES_W'(rem_sh - {1'b0, div_reg}) : rem_sh[RES_W-1:0];
    assign dbl     = {acc_reg, 1'b0};
    assign dbl_r   = (dbl >= mz) ? RES_W'(dbl - mz) : dbl[RES_W-1:0];
    assign sum     = {1'b0, dbl_r} + (qbit ? {1'b0, x1_reg} : '0);
    assign acc_new = (sum >= mz) ? RES_W'(sum - mz) : sum[RES_W-1:0];

    assign t_wide  = (x0_reg >= acc_reg) ? {1'b0, x0_reg} - {1'b0, acc_reg}
                                         : {1'b0, x0_reg} + mz - {1'b0, acc_reg};
    assign t_val   = t_wide[RES_W-1:0];
    assign mul_src = (op_reg == OP_MUL) ? b_reg : x0_reg;
    assign mag     = s_data.wide_value[WIDE_W-1] ? WIDE_W'(-s_data.wide_value)
                                                 : s_data.wide_value;
    assign s_add   = {1'b0, a_reg} + {1'b0, b_reg};
    assign a_inc   = {1'b0, a_reg} + 32'd1;

    always_comb begin
        fin = '0;
        unique case (op_reg)
            OP_ADD: fin.result = (s_add >= mz) ? RES_W'(s_add - mz) : s_add[RES_W-1:0];
            OP_SUB: fin.result = (a_reg >= b_reg) ? a_reg - b_reg
                                                   : RES_W'(mz + {1'b0, a_reg} - {1'b0, b_reg});
            OP_MUL: fin.result = rem_reg;
            OP_DIV: begin
                fin.not_invertible = (ra_reg != 31'd1);
                fin.result = (ra_reg != 31'd1) ? '0 : rem_reg;
            end
            OP_NEG: fin.result = (a_reg != '0) ? m_eff - a_reg : '0;
            OP_INC: fin.result = (a_inc == mz) ? '0 : a_inc[RES_W-1:0];
            OP_DEC: fin.result = (a_reg != '0) ? a_reg - 31'd1 : m_eff - 31'd1;
            OP_RED: fin.result = (neg_reg && rem_reg != '0) ? m_eff - rem_reg : rem_reg;
            OP_EQ:  fin.result = RES_W'(a_reg == b_reg);
            default: fin = '0;
        endcase
    end

    always_comb begin
        mod_next = mod_reg;  op_next = op_reg;  a_next = a_reg;  b_next = b_reg;
        neg_next = neg_reg;  wide_next = wide_reg;  num_next = num_reg;
        rem_next = rem_reg;  div_next = div_reg;  acc_next = acc_reg;
        x0_next = x0_reg;  x1_next = x1_reg;  ra_next = ra_reg;  rb_next = rb_reg;
        prod_next = prod_reg;  cnt_next = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next = m_data_reg;
        if (cfg_wr_en) begin
            mod_next = cfg_wr_data;
        end
        unique case (cmd.code)
            CMD_LOAD: begin
                op_next = s_data.op;
                // raw operand_b waits here until its own reduction starts
                b_next = s_data.operand_b;
                neg_next = s_data.wide_value[WIDE_W-1];
                wide_next = mag;
                num_next = {s_data.operand_a, 33'd0};
                rem_next = '0;
                cnt_next = CNT_W'(RES_W);
                div_next = m_eff;
            end
            CMD_STEP: begin
                num_next = {num_reg[WIDE_W-2:0], 1'b0};
                rem_next = rem_new;
                acc_next = acc_new;
                cnt_next = cnt_reg - 7'd1;
            end
            CMD_SAVE_A: begin
                a_next = rem_reg;
                num_next = {b_reg, 33'd0};
                rem_next = '0;
                cnt_next = CNT_W'(RES_W);
            end
            CMD_SAVE_B: b_next = rem_reg;
            CMD_MUL: prod_next = (2*RES_W)'(a_reg) * (2*RES_W)'(mul_src);
            CMD_RP_INIT: begin
                num_next = {2'b00, prod_reg};
                rem_next = '0;
                cnt_next = CNT_W'(WIDE_W);
                div_next = m_eff;
            end
            CMD_RW_INIT: begin
                num_next = wide_reg;
                rem_next = '0;
                cnt_next = CNT_W'(WIDE_W);
            end
            CMD_EU_INIT: begin
                ra_next = b_reg;
                rb_next = m_eff;
                x0_next = (m_eff == 31'd1) ? '0 : 31'd1;
                x1_next = '0;
            end
            CMD_DV_INIT: begin
                num_next = {ra_reg, 33'd0};
                rem_next = '0;
                cnt_next = CNT_W'(RES_W);
                div_next = rb_reg;
                acc_next = '0;
            end
            CMD_EU_UPD: begin
                x0_next = x1_reg;
                x1_next = t_val;
                ra_next = rb_reg;
                rb_next = rem_reg;
            end
            CMD_FINISH: begin
                m_valid_next = 1'b1;
                m_data_next = fin;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= MOD_RESET;
            m_valid_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            mod_reg <= mod_next;
            m_valid_reg <= m_valid_next;
            cnt_reg <= cnt_next;
        end
        op_reg <= op_next;  a_reg <= a_next;  b_reg <= b_next;
        neg_reg <= neg_next;  wide_reg <= wide_next;  num_reg <= num_next;
        rem_reg <= rem_next;  div_reg <= div_next;  acc_reg <= acc_next;
        x0_reg <= x0_next;  x1_reg <= x1_next;  ra_reg <= ra_next;  rb_reg <= rb_next;
        prod_reg <= prod_next;  m_data_reg <= m_data_next;
    end

    assign stat.last     = (cnt_reg == 7'd1);
    assign stat.rb_zero  = (rb_reg == '0);
    assign stat.ra_one   = (ra_reg == 31'd1);
    assign stat.out_busy = m_valid_reg && !m_ready;
    assign stat.op       = op_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[design/mau_ctrl.sv]
// Controller: sequences reductions, multiply and extended Euclid steps.
`timescale 1ns / 1ps
module mau_ctrl
    import mau_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  mau_stat_t stat,
    output mau_cmd_t  cmd
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_REDA   = 14'b00000000000010,
        S_SAVEA  = 14'b00000000000100,
        S_REDB   = 14'b00000000001000,
        S_DISP   = 14'b00000000010000,
        S_MUL    = 14'b00000000100000,
        S_RPINIT = 14'b00000001000000,
        S_REDP   = 14'b00000010000000,
        S_REDW   = 14'b00000100000000,
        S_EUINIT = 14'b00001000000000,
        S_EUCHK  = 14'b00010000000000,
        S_EUDIV  = 14'b00100000000000,
        S_EUUPD  = 14'b01000000000000,
        S_FIN    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd.code = CMD_NONE;
        unique case (state_reg)
            S_IDLE: if (s_valid) begin
                cmd.code = CMD_LOAD;
                state_next = S_REDA;
            end
            S_REDA: begin
                cmd.code = CMD_STEP;
                if (stat.last) state_next = S_SAVEA;
            end
            S_SAVEA: begin
                cmd.code = CMD_SAVE_A;
                state_next = S_REDB;
            end
            S_REDB: begin
                cmd.code = CMD_STEP;
                if (stat.last) state_next = S_DISP;
            end
            S_DISP: begin
                cmd.code = CMD_SAVE_B;
                if (stat.op == OP_MUL) state_next = S_MUL;
                else if (stat.op == OP_DIV) state_next = S_EUINIT;
                else if (stat.op == OP_RED) state_next = S_REDW;
                else state_next = S_FIN;
            end
            S_MUL: begin
                cmd.code = CMD_MUL;
                state_next = S_RPINIT;
            end
            S_RPINIT: begin
                cmd.code = CMD_RP_INIT;
                state_next = S_REDP;
            end
            S_REDP: begin
                cmd.code = CMD_STEP;
                if (stat.last) state_next = S_FIN;
            end
            S_REDW: begin
                // first visit loads the magnitude, then one bit per cycle
                cmd.code = CMD_RW_INIT;
                state_next = S_REDP;
            end
            S_EUINIT: begin
                cmd.code = CMD_EU_INIT;
                state_next = S_EUCHK;
            end
            S_EUCHK: begin
                if (stat.rb_zero) begin
                    state_next = stat.ra_one ? S_MUL : S_FIN;
                end else begin
                    cmd.code = CMD_DV_INIT;
                    state_next = S_EUDIV;
                end
            end
            S_EUDIV: begin
                cmd.code = CMD_STEP;
                if (stat.last) state_next = S_EUUPD;
            end
            S_EUUPD: begin
                cmd.code = CMD_EU_UPD;
                state_next = S_EUCHK;
            end
            S_FIN: if (!stat.out_busy) begin
                cmd.code = CMD_FINISH;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

[design/modular_arithmetic_unit.sv]
// Top level of the modular arithmetic unit.
//
// Input channel s_valid/s_ready/s_data carries one request: opcode, two residues
// and a signed 64-bit value. Output channel m_valid/m_ready/m_data returns one
// residue and the not_invertible flag per request, in order.
// cfg_wr_en/cfg_wr_data write the modulus; write it only while idle.
// One request is processed at a time through a serial remainder unit that
// retires one bit per cycle. Every request first reduces both operands;
// multiply and reduce then run a 64-bit reduction, and divide runs extended
// Euclid steps, each a serial division, and for an invertible divisor a
// final multiply and 64-bit reduction.
// A new request is taken the cycle after the previous result is registered,
// while that result may still wait for m_ready.
// Reset sets the modulus to 1000000007 and empties the output register.
// If the receiver stalls, the finished result holds and the next request
// waits in its final state until the output register frees.
`timescale 1ns / 1ps
module modular_arithmetic_unit
    import mau_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [RES_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  mau_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output mau_out_t         m_data
);

    mau_cmd_t  cmd;
    mau_stat_t stat;

    mau_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mau_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

[design/mau_checker.sv]
// Port-level checker for the modular arithmetic unit, with its bind.
`timescale 1ns / 1ps
`include "modular_arithmetic_unit_assert.svh"
module mau_port_checker
    import mau_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input mau_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input mau_out_t m_data
);

    `MAU_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data))
    `MAU_ASSERT(a_one_at_a_time, s_valid && s_ready |=> !s_ready)
    `MAU_ASSERT(a_flag_zero_result, m_valid && m_data.not_invertible |-> m_data.result == '0)
    `MAU_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid)

endmodule

bind modular_arithmetic_unit mau_port_checker u_mau_checker (.*);

[tb/mau_checker.sv]
// Result checker for the modular arithmetic unit: predicts each request and compares.
`timescale 1ns / 1ps
module mau_checker
    import mau_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [RES_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  mau_in_t          s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  mau_out_t         m_data,
    output int               err_count,
    output int               pending_count,
    output int               result_count
);

    logic [RES_W-1:0] modulus_q;
    mau_out_t residue_fifo[$];

    // Modulus below 2 behaves as 1.
    function automatic mau_out_t modular_answer(mau_in_t d, logic [RES_W-1:0] mreg);
        longint unsigned m, a, b, res, q, r, ra, rb, mag;
        longint x0, x1, t, v;
        mau_out_t o;
        m = (mreg < 2) ? 64'd1 : 64'(mreg);
        a = 64'(d.operand_a) % m;
        b = 64'(d.operand_b) % m;
        res = 0;
        o.not_invertible = 1'b0;
        case (d.op)
            OP_ADD: begin
                res = a + b;
                if (res >= m) res = res - m;
            end
            OP_SUB: res = (a >= b) ? a - b : a + m - b;
            OP_MUL: res = (a * b) % m;
            OP_DIV: begin
                x0 = 1; x1 = 0; ra = b; rb = m;
                while (rb != 0) begin
                    q = ra / rb;
                    r = ra % rb;
                    t = x0 - longint'(q) * x1;
                    x0 = x1; x1 = t; ra = rb; rb = r;
                end
                if (ra != 1) begin
                    o.not_invertible = 1'b1;
                end else begin
                    v = x0 % longint'(m);
                    if (v < 0) v = v + longint'(m);
                    res = (a * longint'(v)) % m;
                end
            end
            OP_NEG: res = (a != 0) ? m - a : 0;
            OP_INC: res = (a + 1 == m) ? 0 : a + 1;
            OP_DEC: res = (a != 0) ? a - 1 : m - 1;
            OP_RED: begin
                if (d.wide_value[63]) begin
                    mag = ~longint'(d.wide_value) + 1;
                    r = mag % m;
                    res = (r != 0) ? m - r : 0;
                end else begin
                    res = longint'(d.wide_value) % m;
                end
            end
            OP_EQ: res = (a == b) ? 1 : 0;
            default: res = 0;
        endcase
        o.result = res[RES_W-1:0];
        return o;
    endfunction

    assign pending_count = residue_fifo.size();

    always @(posedge aclk) begin
        mau_out_t exp_r;
        if (!aresetn) begin
            modulus_q <= MOD_RESET;
            err_count <= 0;
            result_count <= 0;
            residue_fifo.delete();
        end else begin
            if (cfg_wr_en) modulus_q <= cfg_wr_data;
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (residue_fifo.size() == 0) begin
                    err_count <= err_count + 1;
                    if (err_count < 10)
                        $display("unexpected result %0d/%0b", m_data.result,
                                 m_data.not_invertible);
                end else begin
                    exp_r = residue_fifo.pop_front();
                    if (exp_r != m_data) begin
                        err_count <= err_count + 1;
                        if (err_count < 10)
                            $display("mismatch: exp %0d/%0b got %0d/%0b", exp_r.result,
                                     exp_r.not_invertible, m_data.result,
                                     m_data.not_invertible);
                    end
                end
            end
            if (s_valid && s_ready)
                residue_fifo.push_back(modular_answer(s_data, modulus_q));
        end
    end

endmodule

[tb/tb_modular_arithmetic_unit.sv]
// Testbench top for the modular arithmetic unit: stimulus, modulus phases, verdict.
`timescale 1ns / 1ps
module tb_modular_arithmetic_unit;
    import mau_pkg::*;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [RES_W-1:0] cfg_wr_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    mau_in_t          s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    mau_out_t         m_data;
    int               err_count, pending_count, result_count;
    int               accept_count = 0;
    int               burst_left = 0;
    int               sent_count = 0;
    logic [RES_W-1:0] cur_mod = MOD_RESET;
    logic [RES_W-1:0] mod_list[8];

    always #6 aclk = ~aclk;

    modular_arithmetic_unit uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    mau_checker chk (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .err_count(err_count), .pending_count(pending_count), .result_count(result_count)
    );

    always @(posedge aclk)
        if (s_valid && s_ready) accept_count <= accept_count + 1;

    // Receiver: alternating calm and stall-heavy stretches.
    always @(negedge aclk) begin
        int seg;
        seg = int'(($time / 12) % 600);
        if (!aresetn || seg < 200) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input mau_in_t d);
        int gap, seen;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_valid <= 1'b1;
        s_data <= d;
        seen = accept_count;
        do @(negedge aclk); while (accept_count == seen);
        burst_left--;
        sent_count++;
    endtask

    function automatic logic [RES_W-1:0] pick_residue(logic [RES_W-1:0] m);
        int unsigned sel, em;
        sel = $urandom_range(0, 9);
        em = (m < 2) ? 1 : m;
        case (sel)
            0: return '0;
            1: return RES_W'(em - 1);
            2: return RES_W'($urandom());
            default: return RES_W'($urandom() % em);
        endcase
    endfunction

    function automatic mau_in_t random_request(logic [RES_W-1:0] m);
        mau_in_t d;
        d.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
        d.operand_a = pick_residue(m);
        d.operand_b = ($urandom_range(0, 7) == 0) ? d.operand_a : pick_residue(m);
        case ($urandom_range(0, 5))
            0: d.wide_value = 64'($signed($urandom_range(0, 2000)) - 1000);
            1: d.wide_value = {1'b1, 63'd0};
            default: d.wide_value = {$urandom(), $urandom()};
        endcase
        return d;
    endfunction

    task automatic directed_request(input logic [3:0] op, input logic [RES_W-1:0] a,
                                    input logic [RES_W-1:0] b, input logic [63:0] w);
        mau_in_t d;
        d.op = op; d.operand_a = a; d.operand_b = b; d.wide_value = w;
        send_request(d);
    endtask

    task automatic write_modulus(input logic [RES_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_mod = v;
        @(negedge aclk);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        burst_left = 0;
        wait (pending_count == 0);
        repeat (10) @(negedge aclk);
    endtask

    initial begin
        #200_000_000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        mod_list = '{31'h7FFFFFFF, 31'd2, 31'd12, 31'd0, 31'd1, 31'h40000000,
                     31'd0, 31'd1000000007};
        mod_list[6] = RES_W'($urandom_range(3, 32'h7FFFFFFF));
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed requests under the reset modulus.
        directed_request(OP_ADD, RES_W'(MOD_RESET - 1), RES_W'(MOD_RESET - 1), 0);
        directed_request(OP_ADD, 0, 0, 0);
        directed_request(OP_SUB, 0, RES_W'(MOD_RESET - 1), 0);
        directed_request(OP_SUB, 31'h7FFFFFFF, 31'h7FFFFFFF, 0);
        directed_request(OP_MUL, RES_W'(MOD_RESET - 1), RES_W'(MOD_RESET - 1), 0);
        directed_request(OP_DIV, 5, 0, 0);                    // zero divisor
        directed_request(OP_DIV, RES_W'(MOD_RESET - 1), 2, 0);
        directed_request(OP_DIV, 1, MOD_RESET, 0);            // divisor reduces to 0
        directed_request(OP_NEG, 0, 0, 0);
        directed_request(OP_NEG, 1, 0, 0);
        directed_request(OP_INC, RES_W'(MOD_RESET - 1), 0, 0);
        directed_request(OP_DEC, 0, 0, 0);
        directed_request(OP_DEC, 31'h7FFFFFFF, 0, 0);         // operand above modulus
        directed_request(OP_RED, 0, 0, {1'b1, 63'd0});
        directed_request(OP_RED, 0, 0, {1'b0, {63{1'b1}}});
        directed_request(OP_RED, 0, 0, -64'sd1);
        directed_request(OP_RED, 0, 0, 64'(-64'sd1000000007));
        directed_request(OP_EQ, 3, RES_W'(MOD_RESET + 3), 0); // equal after reduction
        directed_request(OP_EQ, 3, 4, 0);
        directed_request(4'd9, 7, 7, 0);
        directed_request(4'd15, 31'h7FFFFFFF, 31'h7FFFFFFF, {64{1'b1}});
        repeat (200) send_request(random_request(cur_mod));
        drain();

        foreach (mod_list[i]) begin
            write_modulus(mod_list[i]);
            repeat (190) send_request(random_request(cur_mod));
            drain();
        end

        repeat (100) @(negedge aclk);
        $display("%0d requests sent, %0d results checked, 9 modulus settings", sent_count,
                 result_count);
        $display("covered all opcodes, unused codes, non-invertible divisors, moduli 0..2^31-1");
        if (err_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d errors, %0d results missing", err_count, pending_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
